// ===== src/ax25_ui_frame_encoder_macros.svh =====
// assertion macros for the ax.25 ui frame encoder
`ifndef AX25_UI_FRAME_ENCODER_MACROS_SVH
`define AX25_UI_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define AX25_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AX25_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ax25enc_pkg.sv =====
// shared types, constants and helper functions of the ax.25 ui frame encoder
`timescale 1ns / 1ps
`default_nettype none

package ax25enc_pkg;

    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [7:0]  CTL_UI         = 8'h03;
    localparam logic [7:0]  PID_NONE       = 8'hF0;
    localparam logic [7:0]  SSID_DEST_BASE = 8'h60;
    localparam logic [7:0]  SSID_SRC_BASE  = 8'h61;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT     = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN_LAST = 3'd4;
    localparam logic [3:0]  HDR_LAST_IDX   = 4'd15;

    localparam int CALL_W = 48;
    localparam int SSID_W = 4;
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DEST_CALL = 2'd0;
    localparam logic [1:0] REG_SRC_CALL  = 2'd1;
    localparam logic [1:0] REG_DEST_SID  = 2'd2;
    localparam logic [1:0] REG_SRC_SID   = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_OPEN,
        OP_HDR,
        OP_PAY,
        OP_FCS_HI,
        OP_FCS_LO,
        OP_FLAG,
        OP_PAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] hdr_idx;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic room;
        logic empty;
    } sts_t;

    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] n;
        logic [2:0] ones;
    } stuff_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = v[k];
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] v);
        logic [15:0] c;
        c = c_in ^ {v, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // stuffed bits come back msb-aligned, 8 to 10 of them
    function automatic stuff_t stuff_byte(input logic [7:0] v, input logic [2:0] ones_in);
        logic [9:0] r;
        logic [3:0] n;
        logic [2:0] run;
        stuff_t     res;
        r   = '0;
        n   = '0;
        run = ones_in;
        for (int k = 7; k >= 0; k--) begin
            r = {r[8:0], v[k]};
            n = n + 4'd1;
            if (v[k]) begin
                if (run == STUFF_RUN_LAST) begin
                    r   = {r[8:0], 1'b0};
                    n   = n + 4'd1;
                    run = '0;
                end else begin
                    run = run + 3'd1;
                end
            end else begin
                run = '0;
            end
        end
        res.bits = r << (4'd10 - n);
        res.n    = n;
        res.ones = run;
        return res;
    endfunction

    // header byte by position: dest call, dest ssid, src call, src ssid, control, pid
    function automatic logic [7:0] hdr_byte(
        input logic [3:0]        idx,
        input logic [CALL_W-1:0] dest_call,
        input logic [CALL_W-1:0] src_call,
        input logic [SSID_W-1:0] dest_sid,
        input logic [SSID_W-1:0] source_sid
    );
        logic [7:0] b;
        logic [7:0] ch;
        int         sh;
        b  = '0;
        ch = '0;
        sh = 0;
        if (idx < 4'd6) begin
            sh = 8 * (5 - int'(idx));
            ch = 8'(dest_call >> sh);
            b  = {ch[6:0], 1'b0};
        end else if (idx == 4'd6) begin
            b = SSID_DEST_BASE | {3'b000, dest_sid, 1'b0};
        end else if (idx < 4'd13) begin
            sh = 8 * (12 - int'(idx));
            ch = 8'(src_call >> sh);
            b  = {ch[6:0], 1'b0};
        end else if (idx == 4'd13) begin
            b = SSID_SRC_BASE | {3'b000, source_sid, 1'b0};
        end else if (idx == 4'd14) begin
            b = CTL_UI;
        end else begin
            b = PID_NONE;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== src/ax25enc_cfg.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module ax25enc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ax25enc_pkg::CFG_AW-1:0]   paddr,
    input  logic [ax25enc_pkg::CFG_DW-1:0]   pwdata,
    output logic [ax25enc_pkg::CFG_DW-1:0]   prdata,
    output logic                             pready,
    output logic [ax25enc_pkg::CALL_W-1:0]   dest_call,
    output logic [ax25enc_pkg::CALL_W-1:0]   src_call,
    output logic [ax25enc_pkg::SSID_W-1:0]   dest_sid,
    output logic [ax25enc_pkg::SSID_W-1:0]   source_sid
);

    logic [ax25enc_pkg::CALL_W-1:0] dest_call_reg;
    logic [ax25enc_pkg::CALL_W-1:0] src_call_reg;
    logic [ax25enc_pkg::SSID_W-1:0] dest_sid_reg;
    logic [ax25enc_pkg::SSID_W-1:0] source_sid_reg;
    logic [1:0]                     reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_call_reg  <= '0;
            src_call_reg   <= '0;
            dest_sid_reg   <= '0;
            source_sid_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                ax25enc_pkg::REG_DEST_CALL: dest_call_reg  <= pwdata[ax25enc_pkg::CALL_W-1:0];
                ax25enc_pkg::REG_SRC_CALL:  src_call_reg   <= pwdata[ax25enc_pkg::CALL_W-1:0];
                ax25enc_pkg::REG_DEST_SID:  dest_sid_reg   <= pwdata[ax25enc_pkg::SSID_W-1:0];
                ax25enc_pkg::REG_SRC_SID:   source_sid_reg <= pwdata[ax25enc_pkg::SSID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ax25enc_pkg::REG_DEST_CALL:
                prdata = ax25enc_pkg::CFG_DW'(dest_call_reg);
            ax25enc_pkg::REG_SRC_CALL:
                prdata = ax25enc_pkg::CFG_DW'(src_call_reg);
            ax25enc_pkg::REG_DEST_SID:
                prdata = ax25enc_pkg::CFG_DW'(dest_sid_reg);
            ax25enc_pkg::REG_SRC_SID:
                prdata = ax25enc_pkg::CFG_DW'(source_sid_reg);
            default:
                prdata = '0;
        endcase
    end

    assign dest_call  = dest_call_reg;
    assign src_call   = src_call_reg;
    assign dest_sid   = dest_sid_reg;
    assign source_sid = source_sid_reg;

endmodule

`default_nettype wire

// ===== src/ax25enc_ctrl.sv =====
// frame sequencer: walks open flag, header, payload, fcs, closing flag and pad
`timescale 1ns / 1ps
`default_nettype none

module ax25enc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  ax25enc_pkg::sts_t   sts,
    output ax25enc_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_HDR,
        ST_PAY,
        ST_FCS_HI,
        ST_FCS_LO,
        ST_FLAG,
        ST_PAD
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic       last_reg, last_next;
    logic       in_frame_reg, in_frame_next;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        in_frame_next = in_frame_reg;
        s_tready      = (state_reg == ST_IDLE);
        cmd.op        = ax25enc_pkg::OP_NONE;
        cmd.hdr_idx   = idx_reg;
        cmd.load      = s_tvalid && s_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tlast;
                    state_next = in_frame_reg ? ST_PAY : ST_OPEN;
                end
            end
            ST_OPEN: begin
                if (sts.room) begin
                    cmd.op        = ax25enc_pkg::OP_OPEN;
                    idx_next      = '0;
                    in_frame_next = 1'b1;
                    state_next    = ST_HDR;
                end
            end
            ST_HDR: begin
                if (sts.room) begin
                    cmd.op   = ax25enc_pkg::OP_HDR;
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == ax25enc_pkg::HDR_LAST_IDX) begin
                        state_next = ST_PAY;
                    end
                end
            end
            ST_PAY: begin
                if (sts.room) begin
                    cmd.op     = ax25enc_pkg::OP_PAY;
                    state_next = last_reg ? ST_FCS_HI : ST_IDLE;
                end
            end
            ST_FCS_HI: begin
                if (sts.room) begin
                    cmd.op     = ax25enc_pkg::OP_FCS_HI;
                    state_next = ST_FCS_LO;
                end
            end
            ST_FCS_LO: begin
                if (sts.room) begin
                    cmd.op     = ax25enc_pkg::OP_FCS_LO;
                    state_next = ST_FLAG;
                end
            end
            ST_FLAG: begin
                if (sts.room) begin
                    cmd.op     = ax25enc_pkg::OP_FLAG;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (sts.room) begin
                    cmd.op        = ax25enc_pkg::OP_PAD;
                    in_frame_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            last_reg     <= 1'b0;
            in_frame_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ax25enc_datapath.sv =====
// crc, bit stuffer, bit packer and output register
`timescale 1ns / 1ps
`default_nettype none

module ax25enc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ax25enc_pkg::cmd_t               cmd,
    output ax25enc_pkg::sts_t               sts,
    input  logic [7:0]                      s_tdata,
    input  logic [ax25enc_pkg::CALL_W-1:0]  dest_call,
    input  logic [ax25enc_pkg::CALL_W-1:0]  src_call,
    input  logic [ax25enc_pkg::SSID_W-1:0]  dest_sid,
    input  logic [ax25enc_pkg::SSID_W-1:0]  source_sid,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast
);

    logic [7:0]  pay_reg, pay_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  ones_reg, ones_next;
    logic [17:0] acc_reg, acc_next;   // msb-aligned bit queue, oldest bit at 17
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_mark_reg, done_mark_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic [7:0]          hdr_b;
    logic [7:0]          body_b;
    logic [7:0]          rbody_b;
    logic [15:0]         fcs;
    logic [7:0]          stuff_in;
    ax25enc_pkg::stuff_t st;
    logic                emit;
    logic                app_en;
    logic [9:0]          app_bits;
    logic [3:0]          app_n;

    always_comb begin
        hdr_b   = ax25enc_pkg::hdr_byte(cmd.hdr_idx, dest_call, src_call, dest_sid, source_sid);
        body_b  = (cmd.op == ax25enc_pkg::OP_HDR) ? hdr_b : pay_reg;
        rbody_b = ax25enc_pkg::rev8(body_b);
        fcs     = crc_reg ^ ax25enc_pkg::CRC_XOROUT;
        case (cmd.op)
            ax25enc_pkg::OP_FCS_HI: stuff_in = fcs[15:8];
            ax25enc_pkg::OP_FCS_LO: stuff_in = fcs[7:0];
            default:                stuff_in = rbody_b;
        endcase
        st = ax25enc_pkg::stuff_byte(stuff_in, ones_reg);
    end

    // a byte leaves only when a full one is queued; commands come only with room
    assign emit = (cnt_reg >= 5'd8) && (!m_valid_reg || m_tready);

    always_comb begin
        pay_next       = pay_reg;
        crc_next       = crc_reg;
        ones_next      = ones_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        done_mark_next = done_mark_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        app_en         = 1'b0;
        app_bits       = st.bits;
        app_n          = st.n;

        if (cmd.load) begin
            pay_next = s_tdata;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next   = 1'b1;
            m_data_next    = acc_reg[17:10];
            m_last_next    = done_mark_reg;
            done_mark_next = 1'b0;
            acc_next       = {acc_reg[9:0], 8'h00};
            cnt_next       = cnt_reg - 5'd8;
        end

        case (cmd.op)
            ax25enc_pkg::OP_OPEN: begin
                acc_next  = {ax25enc_pkg::FLAG_BYTE, 10'b0};
                cnt_next  = 5'd8;
                crc_next  = ax25enc_pkg::CRC_INIT;
                ones_next = '0;
            end
            ax25enc_pkg::OP_HDR, ax25enc_pkg::OP_PAY: begin
                crc_next  = ax25enc_pkg::crc_byte(crc_reg, rbody_b);
                ones_next = st.ones;
                app_en    = 1'b1;
            end
            ax25enc_pkg::OP_FCS_HI, ax25enc_pkg::OP_FCS_LO: begin
                ones_next = st.ones;
                app_en    = 1'b1;
            end
            ax25enc_pkg::OP_FLAG: begin
                // closing flag goes in raw, no stuffing
                app_bits = {ax25enc_pkg::FLAG_BYTE, 2'b00};
                app_n    = 4'd8;
                app_en   = 1'b1;
            end
            ax25enc_pkg::OP_PAD: begin
                // lower bits already zero: a whole zero byte when empty
                cnt_next       = 5'd8;
                done_mark_next = 1'b1;
            end
            default: ;
        endcase

        if (app_en) begin
            acc_next = acc_reg | ({app_bits, 8'h00} >> cnt_reg);
            cnt_next = cnt_reg + {1'b0, app_n};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= ax25enc_pkg::CRC_INIT;
            ones_reg      <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            done_mark_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            ones_reg      <= ones_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            done_mark_reg <= done_mark_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pay_reg    <= pay_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign sts.room  = (cnt_reg < 5'd8);
    assign sts.empty = (cnt_reg == 5'd0);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== src/ax25_ui_frame_encoder.sv =====
// a mid-frame byte takes one packing step and then leaves as up to two finished output bytes;
// the first byte of a frame is preceded by the opening flag and 16 header bytes; the last is
// followed by the fcs, closing flag and pad, each packed and then sent out as output bytes.
// throughput is set by the single bit packer, one packing or one output byte per cycle while
// the line sink accepts bytes.
// reset: synchronous active-low aresetn returns frame state to idle and clears all configuration to zero.
`timescale 1ns / 1ps
`default_nettype none

`include "ax25_ui_frame_encoder_macros.svh"

module ax25_ui_frame_encoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] payload_byte
    input  logic                           s_tlast,   // end_of_payload
    // line byte stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] line_byte
    output logic                           m_tlast,   // frame_done
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ax25enc_pkg::CFG_AW-1:0] paddr,
    input  logic [ax25enc_pkg::CFG_DW-1:0] pwdata,
    output logic [ax25enc_pkg::CFG_DW-1:0] prdata,
    output logic                           pready
);

    ax25enc_pkg::cmd_t              cmd;
    ax25enc_pkg::sts_t              sts;
    logic [ax25enc_pkg::CALL_W-1:0] dest_call;
    logic [ax25enc_pkg::CALL_W-1:0] src_call;
    logic [ax25enc_pkg::SSID_W-1:0] dest_sid;
    logic [ax25enc_pkg::SSID_W-1:0] source_sid;
    logic                           cmd_issued;
    logic                           cmd_open;
    logic                           cmd_pad;
    logic                           byte_queued;

    ax25enc_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .dest_call  (dest_call),
        .src_call   (src_call),
        .dest_sid   (dest_sid),
        .source_sid (source_sid)
    );

    ax25enc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ax25enc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_tdata    (s_tdata),
        .dest_call  (dest_call),
        .src_call   (src_call),
        .dest_sid   (dest_sid),
        .source_sid (source_sid),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    assign cmd_issued  = (cmd.op != ax25enc_pkg::OP_NONE);
    assign cmd_open    = (cmd.op == ax25enc_pkg::OP_OPEN);
    assign cmd_pad     = (cmd.op == ax25enc_pkg::OP_PAD);
    assign byte_queued = !sts.room && !sts.empty;

    // packer never gets bits while a full byte is still queued
    `AX25_ASSERT_NOW(a_cmd_needs_room, aclk, aresetn, cmd_issued, sts.room, "cmd without room")
    // a frame opens only on an empty bit queue
    `AX25_ASSERT_NOW(a_open_on_empty, aclk, aresetn, cmd_open, sts.empty, "open not empty")
    // pad always leaves exactly one full byte queued
    `AX25_ASSERT_NEXT(a_pad_fills_byte, aclk, aresetn, cmd_pad, byte_queued, "pad left no byte")

endmodule

`default_nettype wire

// ===== bench/ax25_ui_frame_encoder_tb.sv =====
// self-checking bench for the ax.25 ui frame encoder: payload frames checked against a line-byte predictor
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] line;
    logic       done;
} line_item_t;

// predicts the packed line bytes of each frame and checks the encoder output against them
class line_byte_scoreboard;
    logic [47:0]  dest_call;
    logic [47:0]  src_call;
    logic [3:0]   dest_sid;
    logic [3:0]   source_sid;
    bit           frame_open;
    logic [15:0]  fcs_acc;
    int           ones_count;
    logic [7:0]   pack_bits;
    int           pack_count;
    line_item_t   expected_lines[$];
    int unsigned  mismatches;
    int unsigned  lines_checked;

    function new();
        dest_call = '0;
        src_call = '0;
        dest_sid = '0;
        source_sid = '0;
        mismatches = 0;
        lines_checked = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        frame_open = 1'b0;
        fcs_acc = ax25enc_pkg::CRC_INIT;
        ones_count = 0;
        pack_bits = '0;
        pack_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
        case (idx)
            ax25enc_pkg::REG_DEST_CALL: dest_call = value[47:0];
            ax25enc_pkg::REG_SRC_CALL:  src_call = value[47:0];
            ax25enc_pkg::REG_DEST_SID:  dest_sid = value[3:0];
            ax25enc_pkg::REG_SRC_SID:   source_sid = value[3:0];
            default: ;
        endcase
    endfunction

    function void push_line(logic [7:0] line, logic done);
        line_item_t item;
        item.line = line;
        item.done = done;
        expected_lines.push_back(item);
    endfunction

    function void shift_bit(logic b);
        pack_bits = {pack_bits[6:0], b};
        pack_count++;
        if (pack_count == 8) begin
            push_line(pack_bits, 1'b0);
            pack_bits = '0;
            pack_count = 0;
        end
    endfunction

    function void stuff_octet(logic [7:0] v);
        for (int k = 7; k >= 0; k--) begin
            shift_bit(v[k]);
            if (v[k]) begin
                ones_count++;
                if (ones_count == 5) begin
                    shift_bit(1'b0);
                    ones_count = 0;
                end
            end else begin
                ones_count = 0;
            end
        end
    endfunction

    function void body_octet(logic [7:0] v);
        logic [7:0] r;
        logic       fb;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7 - k];
        end
        // fcs is fed bit-serially with the reversed byte, msb first
        for (int k = 7; k >= 0; k--) begin
            fb = fcs_acc[15] ^ r[k];
            fcs_acc = {fcs_acc[14:0], 1'b0} ^ (fb ? ax25enc_pkg::CRC_POLY : 16'h0000);
        end
        stuff_octet(r);
    endfunction

    function void note_payload(logic [7:0] data, logic eop);
        logic [7:0]  ch;
        logic [7:0]  flag;
        logic [15:0] fcs;
        flag = ax25enc_pkg::FLAG_BYTE;
        if (!frame_open) begin
            clear_frame();
            frame_open = 1'b1;
            push_line(flag, 1'b0);
            for (int k = 5; k >= 0; k--) begin
                ch = dest_call[8*k +: 8];
                body_octet({ch[6:0], 1'b0});
            end
            body_octet(ax25enc_pkg::SSID_DEST_BASE | {3'b000, dest_sid, 1'b0});
            for (int k = 5; k >= 0; k--) begin
                ch = src_call[8*k +: 8];
                body_octet({ch[6:0], 1'b0});
            end
            body_octet(ax25enc_pkg::SSID_SRC_BASE | {3'b000, source_sid, 1'b0});
            body_octet(ax25enc_pkg::CTL_UI);
            body_octet(ax25enc_pkg::PID_NONE);
        end
        body_octet(data);
        if (eop) begin
            fcs = fcs_acc ^ ax25enc_pkg::CRC_XOROUT;
            stuff_octet(fcs[15:8]);
            stuff_octet(fcs[7:0]);
            // closing flag goes out unstuffed
            for (int k = 7; k >= 0; k--) begin
                shift_bit(flag[k]);
            end
            // an aligned flag still gets one whole zero byte after it
            push_line(pack_bits << (8 - pack_count), 1'b1);
            clear_frame();
        end
    endfunction

    function void check_line(logic [7:0] line, logic done);
        line_item_t want;
        if (expected_lines.size() == 0) begin
            $error("unexpected line transfer: line_byte %h frame_done %b", line, done);
            mismatches++;
            return;
        end
        want = expected_lines.pop_front();
        lines_checked++;
        if (line !== want.line) begin
            $error("line_byte mismatch: expected %h, actual %h", want.line, line);
            mismatches++;
        end
        if (done !== want.done) begin
            $error("frame_done mismatch: expected %b, actual %b", want.done, done);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_lines.size();
    endfunction
endclass

module ax25_ui_frame_encoder_tb;

    localparam int CLK_HALF    = 10;
    localparam int MAX_GAP     = 12;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_PAD   = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 160;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // [7:0] payload_byte
    logic                          s_tlast;   // end_of_payload
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;   // [7:0] line_byte
    logic                          m_tlast;   // frame_done
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ax25enc_pkg::CFG_AW-1:0] paddr;
    logic [ax25enc_pkg::CFG_DW-1:0] pwdata;
    logic [ax25enc_pkg::CFG_DW-1:0] prdata;
    logic                          pready;

    line_byte_scoreboard line_sb;
    bit                  tx_quiet;
    bit                  rx_quiet;
    bit                  hold_request;
    int                  bytes_sent;
    int                  frames_sent;
    int                  settings_used;
    int                  long_holds;
    int                  stall_count;

    ax25_ui_frame_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic int pick_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [47:0] make_callsign();
        logic [47:0] c;
        int          used;
        c = '0;
        used = $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0) begin
            c = {16'($urandom), $urandom};
        end else begin
            // letters and digits, nul padded at the low end
            for (int k = 0; k < used; k++) begin
                c[8*(5-k) +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(48, 57))
                                                              : 8'($urandom_range(65, 90));
            end
        end
        return c;
    endfunction

    // ends in the access phase; configure releases the bus after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        line_sb.set_reg(idx, value);
        @(negedge aclk);
    endtask

    // unused upper bits of pwdata carry noise
    task automatic configure(input logic [47:0] dc, input logic [47:0] sc,
                             input logic [3:0] ds, input logic [3:0] ss);
        write_reg(ax25enc_pkg::REG_DEST_CALL, {16'($urandom), dc});
        write_reg(ax25enc_pkg::REG_SRC_CALL, {16'($urandom), sc});
        write_reg(ax25enc_pkg::REG_DEST_SID, {$urandom, 28'($urandom), ds});
        write_reg(ax25enc_pkg::REG_SRC_SID, {$urandom, 28'($urandom), ss});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    // called and returns at a falling edge; tvalid stays up for a back-to-back transfer
    task automatic send_byte(input logic [7:0] data, input logic eop);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tlast <= eop;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        line_sb.note_payload(data, eop);
        bytes_sent++;
        if (eop) frames_sent++;
        @(negedge aclk);
    endtask

    task automatic random_frame(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom), k == len - 1);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (line_sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    // no-progress watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d line bytes outstanding",
                         stall_count, line_sb.pending());
                $display("ax25_ui_frame_encoder_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin : line_sink
        int gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request = 1'b0;
                long_holds++;
            end else begin
                gap = pick_gap(rx_quiet);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            line_sb.check_line(m_tdata, m_tlast);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int nframes;
        int len;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        hold_request = 1'b0;
        bytes_sent = 0;
        frames_sent = 0;
        settings_used = 0;
        long_holds = 0;
        stall_count = 0;
        line_sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // registers at their reset value: all-zero callsigns and ssids
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);

        settle();
        configure(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF, 4'hF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        settle();
        configure(48'h4B45_5930_0000, 48'h5A39_5859_5A31, 4'hF, 4'h0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h81, 1'b1);

        // sink holds off while a long frame keeps coming, so the encoder backs up
        settle();
        configure(make_callsign(), make_callsign(), 4'($urandom), 4'($urandom));
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        hold_request = 1'b1;
        random_frame(28);

        while (bytes_sent < ITEM_TARGET) begin
            settle();
            configure(make_callsign(), make_callsign(), 4'($urandom), 4'($urandom));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(1, 4);
            repeat (nframes) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 30)
                                                  : $urandom_range(1, 6);
                random_frame(len);
            end
        end

        settle();
        $display("run: %0d payload bytes in %0d frames under %0d register settings",
                 bytes_sent, frames_sent, settings_used + 1);
        $display("run: %0d line bytes checked, %0d long sink stalls, %0d mismatches",
                 line_sb.lines_checked, long_holds, line_sb.mismatches);
        if (line_sb.mismatches == 0) begin
            $display("ax25_ui_frame_encoder_tb: PASS");
        end else begin
            $display("ax25_ui_frame_encoder_tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/ax25enc_pkg.sv
src/ax25enc_cfg.sv
src/ax25enc_ctrl.sv
src/ax25enc_datapath.sv
src/ax25_ui_frame_encoder.sv
bench/ax25_ui_frame_encoder_tb.sv
